FILE: src/stack_machine_execute_step_core_macros.svh
// ---------------------------------------------------------------------------
// Stack machine execute step - assertion macros
// Shared concurrent assertion forms for the execute core.
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_STEP_CORE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_STEP_CORE_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/smx_pkg.sv
// ---------------------------------------------------------------------------
// Stack machine execute step - package
// Widths, opcodes, status codes and the stack command struct.
// ---------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int PC_W            = 16;
    localparam int DATA_W          = 32;
    localparam int CMD_W           = 4;
    localparam int STAT_W          = 3;
    localparam int CNT_W           = 9;

    typedef enum logic [CMD_W-1:0] {
        OP_HALT  = 4'd0,
        OP_PUSH  = 4'd1,
        OP_POP   = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_PRINT = 4'd5,
        OP_READ  = 4'd6,
        OP_JEQ0  = 4'd7,
        OP_JGT0  = 4'd8
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_RUN     = 3'd0,
        ST_HALT    = 3'd1,
        ST_END     = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_UNDER   = 3'd4,
        ST_OVER    = 3'd5
    } t_status;

    // one-hot at most: push, pop or alu
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              alu;
        logic              sub;
        logic [DATA_W-1:0] value;
    } t_stack_cmd;

endpackage

FILE: src/smx_if.sv
// ---------------------------------------------------------------------------
// Stack machine execute step - channel interfaces
// Instruction word channel and result word channel, valid/ready.
// ---------------------------------------------------------------------------
interface smx_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [31:0] immediate;
    logic [15:0]        jump_target;
    logic signed [31:0] read_value;

    modport source (output valid, command, immediate, jump_target, read_value,
                    input ready);
    modport sink   (input valid, command, immediate, jump_target, read_value,
                    output ready);
endinterface

interface smx_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic [2:0]         run_status;
    logic               print_request;
    logic [15:0]        print_address;
    logic signed [31:0] top_value;
    logic [8:0]         stack_count;

    modport source (output valid, next_pc, run_status, print_request, print_address,
                    top_value, stack_count, input ready);
    modport sink   (input valid, next_pc, run_status, print_request, print_address,
                    top_value, stack_count, output ready);
endinterface

FILE: src/smx_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/smx_stack.sv
// ---------------------------------------------------------------------------
// Stack machine execute step - operand stack
// Top entry in a register, lower entries in RAM; next-of-stack is read
// ahead every cycle with a bypass for the entry just written.
// ---------------------------------------------------------------------------
module smx_stack
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int SPW        = $clog2(STACK_DEPTH + 1),
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stack_cmd        i_op,
    output logic [DATA_W-1:0] o_top,
    output logic [SPW-1:0]    o_sp
);

    logic [DATA_W-1:0] r_top, n_top;
    logic [SPW-1:0]    r_sp, n_sp;
    logic              r_fwd_hit, n_fwd_hit;
    logic [DATA_W-1:0] r_fwd_data;

    logic [SPW-1:0]    w_wr_idx, w_rd_idx;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic              w_we;
    logic [DATA_W-1:0] w_rdata, w_nos;

    assign w_nos = r_fwd_hit ? r_fwd_data : w_rdata;

    always_comb begin
        n_top = r_top;
        n_sp  = r_sp;
        w_we  = 1'b0;
        if (i_op.push) begin
            n_top = i_op.value;
            n_sp  = r_sp + SPW'(1);
            w_we  = (r_sp != '0);
        end else if (i_op.pop) begin
            n_top = w_nos;
            n_sp  = r_sp - SPW'(1);
        end else if (i_op.alu) begin
            n_top = i_op.sub ? (w_nos - r_top) : (w_nos + r_top);
            n_sp  = r_sp - SPW'(1);
        end
    end

    // old top goes below the new one; read ahead the entry under the next top
    assign w_wr_idx  = r_sp - SPW'(1);
    assign w_rd_idx  = n_sp - SPW'(2);
    assign w_waddr   = w_wr_idx[AW-1:0];
    assign w_raddr   = w_rd_idx[AW-1:0];
    assign n_fwd_hit = w_we && (w_waddr == w_raddr);

    smx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_sp      <= n_sp;
            r_fwd_hit <= n_fwd_hit;
        end
        r_top      <= n_top;
        r_fwd_data <= r_top;
    end

    assign o_top = r_top;
    assign o_sp  = r_sp;

endmodule

FILE: src/stack_machine_execute_step_core.sv
// ---------------------------------------------------------------------------
// Stack machine execute step core
// Latency: a result word is valid the cycle after its instruction is taken.
// Throughput: one instruction per cycle unless o_res stalls, held by the
// top-of-stack register and the next-of-stack read-ahead through the single
// read port of the stack RAM. Reset clears pc, stack pointer, status and
// program length; stack RAM is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "stack_machine_execute_step_core_macros.svh"

module stack_machine_execute_step_core
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int SPW        = $clog2(STACK_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [PC_W-1:0] i_cfg_data,
    smx_in_if.sink          i_cmd,
    smx_out_if.source       o_res
);

    logic [PC_W-1:0] r_prog_len;
    logic [PC_W-1:0] r_pc, n_pc;
    t_status         r_status, n_status;
    logic            r_out_valid, n_out_valid;
    logic            r_prq, n_prq;
    logic [PC_W-1:0] r_paddr, n_paddr;

    t_stack_cmd        w_op;
    logic [DATA_W-1:0] w_top;
    logic [SPW-1:0]    w_sp;
    logic [SPW+CNT_W-1:0] w_sp_ext;
    logic              w_fire, w_empty, w_full, w_lt2, w_taken;
    logic [PC_W-1:0]   w_pc1, w_pc2;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_fire      = i_cmd.valid && i_cmd.ready;

    assign w_empty = (w_sp == '0);
    assign w_full  = (w_sp == SPW'(STACK_DEPTH));
    assign w_lt2   = (w_sp < SPW'(2));
    assign w_pc1   = r_pc + PC_W'(1);
    assign w_pc2   = r_pc + PC_W'(2);
    assign w_taken = (i_cmd.command == OP_JEQ0) ? (w_top == '0)
                                                : (!w_top[DATA_W-1] && (w_top != '0));

    always_comb begin
        n_pc     = r_pc;
        n_status = r_status;
        n_prq    = r_prq;
        n_paddr  = r_paddr;
        w_op     = '0;
        if (w_fire) begin
            n_prq   = 1'b0;
            n_paddr = '0;
            if (r_status == ST_RUN) begin
                if (r_pc >= r_prog_len) begin
                    n_status = ST_END;
                end else begin
                    n_pc = w_pc1;
                    case (i_cmd.command)
                        OP_HALT: begin
                            n_status = ST_HALT;
                        end
                        OP_PUSH, OP_READ: begin
                            if (w_full) begin
                                n_status = ST_OVER;
                            end else begin
                                w_op.push  = 1'b1;
                                w_op.value = (i_cmd.command == OP_PUSH) ? i_cmd.immediate
                                                                        : i_cmd.read_value;
                                if (i_cmd.command == OP_PUSH) begin
                                    n_pc = w_pc2;
                                end
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_status = ST_UNDER;
                            end else begin
                                w_op.pop = 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB: begin
                            if (w_lt2) begin
                                n_status = ST_UNDER;
                            end else begin
                                w_op.alu = 1'b1;
                                w_op.sub = (i_cmd.command == OP_SUB);
                            end
                        end
                        OP_PRINT: begin
                            n_prq   = 1'b1;
                            n_paddr = w_pc1;
                            n_pc    = w_pc2;
                        end
                        OP_JEQ0, OP_JGT0: begin
                            if (w_empty) begin
                                n_status = ST_UNDER;
                            end else begin
                                n_pc = w_taken ? i_cmd.jump_target : w_pc2;
                            end
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                        end
                    endcase
                end
            end
        end
    end

    assign n_out_valid = w_fire || (r_out_valid && !o_res.ready);

    smx_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_top   (w_top),
        .o_sp    (w_sp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len  <= '0;
            r_pc        <= '0;
            r_status    <= ST_RUN;
            r_out_valid <= 1'b0;
            r_prq       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_data;
            end
            r_pc        <= n_pc;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_prq       <= n_prq;
        end
        r_paddr <= n_paddr;
    end

    // result word reflects state after the last taken instruction
    assign w_sp_ext            = {{CNT_W{1'b0}}, w_sp};
    assign o_res.valid         = r_out_valid;
    assign o_res.next_pc       = r_pc;
    assign o_res.run_status    = r_status;
    assign o_res.print_request = r_prq;
    assign o_res.print_address = r_paddr;
    assign o_res.top_value     = w_empty ? '0 : w_top;
    assign o_res.stack_count   = w_sp_ext[CNT_W-1:0];

    `SMX_ASSERT_NXT(a_frozen_hold, i_clk, i_rst_n, r_status != ST_RUN, r_status == $past(r_status), "status left frozen state")
    `SMX_ASSERT_NXT(a_frozen_pc, i_clk, i_rst_n, r_status != ST_RUN, $stable(r_pc), "pc moved while frozen")
    `SMX_ASSERT_NXT(a_fire_word, i_clk, i_rst_n, w_fire, r_out_valid, "taken instruction gave no result word")
    `SMX_ASSERT_IMP(a_print_running, i_clk, i_rst_n, r_out_valid && r_prq, r_status == ST_RUN, "print request with stopped status")

endmodule
